FILE: src/wse_pkg.sv
// Package for the windowed slope estimator.
// Holds shared constants, the controller state type and the command/status structs.
// No dependencies.
package wse_pkg;

   localparam int unsigned DefaultRingDepth = 32;
   localparam logic [31:0] WindowResetValue = 32'd1800000;
   localparam logic [31:0] MinSpanResetValue = 32'd60000;
   localparam logic [31:0] TenMinMs = 32'd600000;

   localparam int unsigned WideBits = 128;
   localparam int unsigned DivSteps = 128;

   localparam logic CsrIndexWindow = 1'b0;
   localparam logic CsrIndexMinSpan = 1'b1;

   localparam logic OpPush = 1'b0;
   localparam logic OpClear = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVICT_READ,
      ST_EVICT_CHECK,
      ST_STORE,
      ST_HEAD_READ,
      ST_SUM_READ,
      ST_SUM_ACC,
      ST_MUL,
      ST_DIV,
      ST_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_item;     // capture input item
      logic clear_ring;    // empty the ring
      logic evict_read;    // read oldest slot time
      logic evict_pop;     // drop oldest
      logic store;         // write new sample
      logic sum_init;      // start sum walk
      logic sum_read;      // read entry at walk index
      logic sum_acc;       // accumulate read entry
      logic mul_step;      // one multiply phase step
      logic div_init;      // start divider
      logic div_step;      // one divider bit
      logic finish;        // form result
      logic out_load;      // put result on output
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic evict_needed;
      logic walk_done;
      logic mul_done;
      logic div_done;
      logic early_zero;    // too few samples or short span
   } status_type;

endpackage

FILE: src/wse_stream_if.sv
// Valid/ready channel interface used for input and result streams.
// No dependencies.
interface wse_stream_if #(
   parameter int unsigned PayloadBits = 1
) ();
   logic valid;
   logic ready;
   logic [PayloadBits-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/wse_ctrl.sv
// Controller state machine of the windowed slope estimator.
// Depends on wse_pkg.
module wse_ctrl
   import wse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic       out_busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_item = 1'b1;
               state_in = ST_EVICT_READ;
            end
         end
         ST_EVICT_READ: begin
            if (status.is_clear) begin
               cmd.clear_ring = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.evict_read = 1'b1;
               state_in = ST_EVICT_CHECK;
            end
         end
         ST_EVICT_CHECK: begin
            if (status.evict_needed) begin
               cmd.evict_pop = 1'b1;
               state_in = ST_EVICT_READ;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in = ST_HEAD_READ;
         end
         ST_HEAD_READ: begin
            cmd.sum_init = 1'b1;
            state_in = ST_SUM_READ;
         end
         ST_SUM_READ: begin
            if (status.early_zero) begin
               state_in = ST_DONE;
            end else if (status.walk_done) begin
               state_in = ST_MUL;
            end else begin
               cmd.sum_read = 1'b1;
               state_in = ST_SUM_ACC;
            end
         end
         ST_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in = ST_SUM_READ;
         end
         ST_MUL: begin
            if (status.mul_done) begin
               cmd.div_init = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_busy) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/wse_datapath.sv
// Datapath of the windowed slope estimator: sample ring memory, sums,
// a shift-and-add multiplier and a restoring divider. Depends on wse_pkg.
module wse_datapath
   import wse_pkg::*;
#(
   parameter int unsigned RingDepth = DefaultRingDepth,
   parameter int unsigned CountBits = $clog2(RingDepth + 1),
   parameter int unsigned SlotBits = $clog2(RingDepth)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_op,
   input  logic [31:0]          in_time_ms,
   input  logic signed [23:0]   in_level,
   input  logic [31:0]          window_ms,
   input  logic [31:0]          span_floor_ms,
   input  cmd_type              cmd,
   output status_type           status,
   output logic signed [31:0]   res_slope,
   output logic                 res_valid,
   output logic [CountBits-1:0] res_count
);

   // The multiplier operand is as wide as the sum of time offsets.
   localparam int unsigned MulBits = 48;

   // Sample ring.
   logic [31:0]        time_mem [RingDepth];
   logic signed [23:0] level_mem [RingDepth];
   logic [31:0]        rd_time_ff;
   logic signed [23:0] rd_level_ff;

   logic                 op_ff;
   logic [31:0]          t_ff;
   logic signed [23:0]   lv_ff;
   logic [SlotBits-1:0]  oldest_ff;
   logic [CountBits-1:0] count_ff;
   logic [SlotBits-1:0]  rd_addr;
   logic [SlotBits-1:0]  wr_slot;
   logic [SlotBits-1:0]  walk_slot;
   logic [CountBits-1:0] walk_ff;
   logic                 walk_started_ff;
   logic [31:0]          t0_ff;
   logic [31:0]          x_val;

   // Sums: x < 2^32, up to RingDepth terms.
   logic [MulBits-1:0]   sx_ff;
   logic signed [39:0]   sy_ff;
   logic [79:0]          sxx_ff;
   logic signed [79:0]   sxy_ff;

   // Multiply phase registers.
   logic [2:0]          mul_ph_ff;
   logic                mul_busy_ff;
   logic [WideBits-1:0] mcand_ff;
   logic [MulBits-1:0]  mplier_ff;
   logic [WideBits-1:0] acc_ff;
   logic [WideBits-1:0] acc_sum;
   logic [WideBits-1:0] den_ff;
   logic [WideBits-1:0] num_ff;
   logic [WideBits-1:0] num_abs;
   logic [WideBits-1:0] pa_ff;
   logic [WideBits-1:0] mag_ff;

   // Divider.
   logic [WideBits-1:0] dq_ff;     // dividend shifting into quotient
   logic [WideBits-1:0] rem_ff;
   logic [WideBits-1:0] dvs_ff;
   logic [7:0]          div_cnt_ff;
   logic                neg_ff;
   logic                den_zero_ff;
   logic [WideBits:0]   rem_shift;
   logic [WideBits:0]   rem_sub;

   logic [SlotBits-1:0] oldest_next;

   // Result formation.
   logic [31:0] sat_val;
   logic        ok;

   function automatic logic [SlotBits-1:0] slot_add(input logic [SlotBits-1:0] a,
                                                   input logic [CountBits-1:0] b);
      logic [CountBits:0] s;
      s = {{(CountBits+1-SlotBits){1'b0}}, a} + {1'b0, b};
      if (s >= (CountBits+1)'(RingDepth)) begin
         s = s - (CountBits+1)'(RingDepth);
      end
      return s[SlotBits-1:0];
   endfunction

   assign oldest_next = slot_add(oldest_ff, CountBits'(1));
   assign wr_slot = slot_add(oldest_ff, count_ff);
   assign walk_slot = slot_add(oldest_ff, walk_ff);
   assign rd_addr = cmd.evict_read ? oldest_ff : walk_slot;
   assign x_val = rd_time_ff - t0_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         time_mem[wr_slot] <= t_ff;
         level_mem[wr_slot] <= lv_ff;
      end
      if (cmd.evict_read || cmd.sum_read || cmd.sum_init) begin
         rd_time_ff <= time_mem[cmd.sum_init ? oldest_ff : rd_addr];
         rd_level_ff <= level_mem[cmd.sum_init ? oldest_ff : rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff <= '0;
      end else if (cmd.clear_ring) begin
         oldest_ff <= '0;
         count_ff <= '0;
      end else if (cmd.evict_pop) begin
         oldest_ff <= oldest_next;
         count_ff <= count_ff - CountBits'(1);
      end else if (cmd.store) begin
         if (count_ff >= CountBits'(RingDepth)) begin
            oldest_ff <= oldest_next;
         end else begin
            count_ff <= count_ff + CountBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff <= in_op;
         t_ff <= in_time_ms;
         lv_ff <= in_level;
      end
   end

   // Full ring with no age eviction pending is handled at the store.
   // Early exit: count below two or span short. Span uses newest time t_ff.
   always_comb begin
      status.is_clear = (op_ff == OpClear);
      status.evict_needed = (count_ff != '0) && ((t_ff - rd_time_ff) > window_ms);
      status.early_zero = !walk_started_ff &&
         ((count_ff < CountBits'(2)) || ((t_ff - rd_time_ff) < span_floor_ms));
      status.walk_done = walk_started_ff && (walk_ff == count_ff);
      status.mul_done = (mul_ph_ff == 3'd5);
      status.div_done = (div_cnt_ff == 8'(DivSteps));
   end

   // Sum walk. walk_ff counts entries accumulated; first read after sum_init
   // gives the oldest time, which becomes the reference.
   always_ff @(posedge clock) begin
      if (cmd.sum_init) begin
         walk_ff <= '0;
         walk_started_ff <= 1'b0;
         sx_ff <= '0;
         sy_ff <= '0;
         sxx_ff <= '0;
         sxy_ff <= '0;
      end else if (cmd.sum_read && !walk_started_ff) begin
         t0_ff <= rd_time_ff;
         walk_started_ff <= 1'b1;
      end else if (cmd.sum_acc) begin
         walk_ff <= walk_ff + CountBits'(1);
         sx_ff <= sx_ff + MulBits'(x_val);
         sy_ff <= sy_ff + 40'(rd_level_ff);
         sxx_ff <= sxx_ff + 80'(64'(x_val) * 64'(x_val));
         sxy_ff <= sxy_ff + 80'($signed({1'b0, x_val}) * 57'(rd_level_ff));
      end
   end

   // Multiply phases, one product each, formed by shift and add over the
   // multiplier bits. A phase loads its operands, adds one multiplier bit per
   // cycle until the multiplier is used up, then combines the product:
   // 0: pa = n*Sxx   1: den = pa - Sx*Sx   2: pa = n*Sxy
   // 3: num = pa - Sx*Sy   4: mag = |num|*1200000 + den, divisor = 2*den
   // Signed multiplicands are sign-extended, so the products wrap to 128 bits.
   assign num_abs = num_ff[WideBits-1] ? ('0 - num_ff) : num_ff;
   assign acc_sum = acc_ff + (mplier_ff[0] ? mcand_ff : '0);

   always_ff @(posedge clock) begin
      if (cmd.sum_init) begin
         mul_ph_ff <= '0;
         mul_busy_ff <= 1'b0;
      end else if (cmd.mul_step) begin
         if (!mul_busy_ff) begin
            mul_busy_ff <= 1'b1;
            acc_ff <= '0;
            unique case (mul_ph_ff)
               3'd0: begin
                  mcand_ff <= WideBits'(sxx_ff);
                  mplier_ff <= MulBits'(count_ff);
               end
               3'd1: begin
                  mcand_ff <= WideBits'(sx_ff);
                  mplier_ff <= sx_ff;
               end
               3'd2: begin
                  mcand_ff <= {{(WideBits-80){sxy_ff[79]}}, sxy_ff};
                  mplier_ff <= MulBits'(count_ff);
               end
               3'd3: begin
                  mcand_ff <= {{(WideBits-40){sy_ff[39]}}, sy_ff};
                  mplier_ff <= sx_ff;
               end
               default: begin
                  neg_ff <= num_ff[WideBits-1];
                  mcand_ff <= num_abs;
                  mplier_ff <= MulBits'(2 * TenMinMs);
               end
            endcase
         end else if (mplier_ff != '0) begin
            acc_ff <= acc_sum;
            mcand_ff <= {mcand_ff[WideBits-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[MulBits-1:1]};
         end else begin
            mul_busy_ff <= 1'b0;
            mul_ph_ff <= mul_ph_ff + 3'd1;
            unique case (mul_ph_ff)
               3'd0, 3'd2: pa_ff <= acc_ff;
               3'd1: den_ff <= pa_ff - acc_ff;
               3'd3: num_ff <= pa_ff - acc_ff;
               default: mag_ff <= acc_ff + den_ff;
            endcase
         end
      end
   end

   assign rem_shift = {rem_ff, dq_ff[WideBits-1]};
   assign rem_sub = rem_shift - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dq_ff <= mag_ff;
         rem_ff <= '0;
         dvs_ff <= {den_ff[WideBits-2:0], 1'b0};
         den_zero_ff <= (den_ff == '0);
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 8'd1;
         if (!rem_sub[WideBits]) begin
            rem_ff <= rem_sub[WideBits-1:0];
            dq_ff <= {dq_ff[WideBits-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[WideBits-1:0];
            dq_ff <= {dq_ff[WideBits-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      ok = !status.is_clear && walk_started_ff && !status.early_zero && !den_zero_ff;
      if (neg_ff) begin
         sat_val = (dq_ff[WideBits-1:32] != '0 || dq_ff[31:0] > 32'h8000_0000) ?
            32'h8000_0000 : (32'd0 - dq_ff[31:0]);
      end else begin
         sat_val = (dq_ff[WideBits-1:32] != '0 || dq_ff[31:0] > 32'h7FFF_FFFF) ?
            32'h7FFF_FFFF : dq_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_valid <= ok;
         res_slope <= ok ? $signed(sat_val) : '0;
         res_count <= count_ff;
      end
   end

endmodule

FILE: src/windowed_slope_estimator.sv
// Top level of the windowed slope estimator.
// Depends on wse_pkg, wse_stream_if, wse_ctrl and wse_datapath.
//
// The block holds up to RING_DEPTH timestamped Q7.16 samples in a ring and, for
// every push transfer, evicts samples older than window_ms, stores the new one and
// returns the least-squares slope per ten minutes in Q15.16, saturated. A clear
// transfer empties the ring and returns zeros. One item is processed at a time.
// A push runs the eviction checks, the store, a walk over the held samples that
// reads and then accumulates each entry, the shift-and-add multiply phases at one
// bit per cycle and the bit-serial 128-step divider, in that order. The length
// of the multiply phases grows with the bit lengths of the held count n and of
// Sx, the sum of the time offsets (at most 37 bits at the default depth). A push
// that yields no slope because too few samples are held or the span is short
// skips the arithmetic. A clear goes from its eviction-read state straight to
// the result. The input is ready again in the cycle the result appears. The
// result waits in an output register until the result transfer completes.
module windowed_slope_estimator
   import wse_pkg::*;
#(
   parameter int unsigned RING_DEPTH = DefaultRingDepth
) (
   input  logic         clock,
   input  logic         reset,
   wse_stream_if.sink   req,
   wse_stream_if.source rsp,
   input  logic         csr_write_enable,
   input  logic         csr_index,
   input  logic [31:0]  csr_write_data
);

   localparam int unsigned CountBits = $clog2(RING_DEPTH + 1);

   logic [31:0] window_ff, min_span_ff;
   cmd_type     cmd;
   status_type  status;

   logic signed [31:0]   res_slope;
   logic                 res_valid;
   logic [CountBits-1:0] res_count;
   logic                 out_valid_ff;
   logic [38:0]          out_payload_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WindowResetValue;
         min_span_ff <= MinSpanResetValue;
      end else if (csr_write_enable) begin
         if (csr_index == CsrIndexWindow) begin
            window_ff <= csr_write_data;
         end
         if (csr_index == CsrIndexMinSpan) begin
            min_span_ff <= csr_write_data;
         end
      end
   end

   wse_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .out_busy (out_valid_ff && !rsp.ready),
      .status   (status),
      .cmd      (cmd)
   );

   wse_datapath #(
      .RingDepth (RING_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .in_op         (req.payload[0]),
      .in_time_ms    (req.payload[32:1]),
      .in_level      (req.payload[56:33]),
      .window_ms     (window_ff),
      .span_floor_ms (min_span_ff),
      .cmd           (cmd),
      .status        (status),
      .res_slope     (res_slope),
      .res_valid     (res_valid),
      .res_count     (res_count)
   );

   // Output register: payload is {held_count, slope_valid, slope_per_10min}.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_payload_ff <= {6'(res_count), res_valid, res_slope};
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_payload_ff;

endmodule

FILE: src/wse_checker.sv
// Port-level checker for the windowed slope estimator, bound to the top level.
// Depends on the top level's ports only.
module wse_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [38:0] rsp_payload
);

   // An invalid slope is always reported as zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload[32] |-> rsp_payload[31:0] == 32'd0)
      else $error("invalid slope not zero");

   // A valid slope needs at least two held samples.
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload[32] |-> rsp_payload[38:33] >= 6'd2)
      else $error("valid slope with too few samples");

   // A stalled result holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // No new item is taken right after one was taken.
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

endmodule

bind windowed_slope_estimator wse_checker u_wse_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);

FILE: tb/sv/wse_slope_checker.sv
// Checker for the windowed slope estimator: watches both channels and the CSR port.
// Keeps its own ring and register copies and compares every result transfer.
// Depends on wse_pkg.
module wse_slope_checker
   import wse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [56:0] req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [38:0] rsp_payload,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data,
   output int          mismatch_count,
   output int          slopes_pending
);

   typedef struct packed {
      logic [5:0]  held;
      logic        valid;
      logic [31:0] slope;
   } slope_result_type;

   slope_result_type slope_expect_q[$];

   logic [31:0] ring_time[DefaultRingDepth];
   logic [23:0] ring_level[DefaultRingDepth];
   logic [4:0]  head_slot;
   int unsigned held_samples;
   logic [31:0] window_reg;
   logic [31:0] min_span_reg;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Least-squares slope over the held samples, all sums in 128-bit wrap arithmetic.
   function automatic slope_result_type fit_slope();
      slope_result_type res;
      logic [31:0]  t0, tn, x;
      logic [127:0] xw, yw, sx, sy, sxx, sxy, den, num, mag, q, n;
      logic [4:0]   k;
      logic         neg;
      res = '0;
      res.held = held_samples[5:0];
      if (held_samples < 2) return res;
      t0 = ring_time[head_slot];
      tn = ring_time[5'(head_slot + held_samples - 1)];
      if (tn - t0 < min_span_reg) return res;
      sx = '0; sy = '0; sxx = '0; sxy = '0;
      n = 128'(held_samples);
      for (int i = 0; i < held_samples; i++) begin
         k = 5'(head_slot + i);
         x = ring_time[k] - t0;
         xw = {96'd0, x};
         yw = {{104{ring_level[k][23]}}, ring_level[k]};
         sx += xw;
         sy += yw;
         sxx += xw * xw;
         sxy += xw * yw;
      end
      den = sxx * n - sx * sx;
      if (den == '0) return res;
      num = sxy * n - sx * sy;
      neg = num[127];
      mag = neg ? -num : num;
      mag = mag * 128'(2 * TenMinMs) + den;
      q = mag / (den << 1);
      res.valid = 1'b1;
      if (neg) res.slope = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
      else res.slope = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      return res;
   endfunction

   task automatic take_item(input logic [56:0] item);
      logic        op;
      logic [31:0] t;
      slope_result_type res;
      op = item[0];
      t = item[32:1];
      if (op == OpClear) begin
         head_slot = '0;
         held_samples = 0;
         slope_expect_q.push_back('0);
         return;
      end
      while (held_samples > 0 && (t - ring_time[head_slot]) > window_reg) begin
         head_slot++;
         held_samples--;
      end
      if (held_samples >= DefaultRingDepth) begin
         head_slot++;
         held_samples = DefaultRingDepth - 1;
      end
      ring_time[5'(head_slot + held_samples)] = t;
      ring_level[5'(head_slot + held_samples)] = item[56:33];
      held_samples++;
      res = fit_slope();
      slope_expect_q.push_back(res);
   endtask

   always @(posedge clock) begin
      slope_result_type got, want;
      if (reset) begin
         head_slot = '0;
         held_samples = 0;
         window_reg = WindowResetValue;
         min_span_reg = MinSpanResetValue;
         slope_expect_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (slope_expect_q.size() == 0) begin
               report_mismatch("unexpected result", {26'd0, got.held}, 32'd0);
            end else begin
               want = slope_expect_q.pop_front();
               if (got.slope !== want.slope) report_mismatch("slope", got.slope, want.slope);
               if (got.valid !== want.valid)
                  report_mismatch("slope_valid", {31'd0, got.valid}, {31'd0, want.valid});
               if (got.held !== want.held)
                  report_mismatch("held_count", {26'd0, got.held}, {26'd0, want.held});
            end
         end
         if (req_valid && req_ready) take_item(req_payload);
         if (csr_write_enable) begin
            if (csr_index == CsrIndexWindow) window_reg = csr_write_data;
            else min_span_reg = csr_write_data;
         end
      end
      slopes_pending = slope_expect_q.size();
   end

endmodule

FILE: tb/sv/tb_windowed_slope_estimator.sv
// Top of the windowed slope estimator testbench: clock, reset, stimulus and verdict.
// Depends on wse_pkg, wse_stream_if, windowed_slope_estimator and wse_slope_checker.
module tb_windowed_slope_estimator;
   import wse_pkg::*;

   localparam int RunLimit = 2000000;
   // The drain time covers the slowest item.
   localparam int DrainCycles = 400;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_index;
   logic [31:0] csr_write_data;
   logic        quiet;
   logic [31:0] sample_time;
   int          mismatch_count;
   int          slopes_pending;
   int          cycle_count;

   wse_stream_if #(.PayloadBits(57)) req_if ();
   wse_stream_if #(.PayloadBits(39)) rsp_if ();

   windowed_slope_estimator dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if.sink),
      .rsp              (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   wse_slope_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_payload      (req_if.payload),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_payload      (rsp_if.payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .slopes_pending   (slopes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The watchdog counts every cycle and ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RunLimit) begin
         $display("[windowed_slope_estimator] ERROR");
         $finish;
      end
   end

   // The result side stalls in random bursts, except in the quiet closing part of the run.
   initial begin
      int burst;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 7);
            rsp_if.ready = 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // Presents one item and holds it until the transfer happens, then may idle a burst.
   task automatic send_item(input logic op, input logic [31:0] t, input logic [23:0] lv);
      req_if.valid = 1'b1;
      req_if.payload = {lv, t, op};
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   task automatic push_sample(input logic [31:0] t, input logic [23:0] lv);
      sample_time = t;
      send_item(OpPush, t, lv);
   endtask

   // Waits for every expected result plus the longest item time, so the block is idle.
   task automatic settle();
      req_if.valid = 1'b0;
      while (slopes_pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [23:0] pick_level();
      case ($urandom_range(0, 9))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h000000;
         default: return 24'($urandom());
      endcase
   endfunction

   // Mostly well-formed time series with increments up to max_step, plus clears, repeated
   // times, backward steps, large forward jumps and completely random times as noise.
   task automatic run_series(input int count, input int unsigned max_step);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) send_item(OpClear, $urandom(), 24'($urandom()));
         else if (pick < 8) push_sample($urandom(), pick_level());
         else if (pick < 11) push_sample(sample_time - $urandom_range(1, 5000), pick_level());
         else if (pick < 14) push_sample(sample_time, pick_level());
         else if (pick < 17) push_sample(sample_time + $urandom_range(0, 4000000), pick_level());
         else push_sample(sample_time + $urandom_range(0, max_step), pick_level());
      end
   endtask

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      cycle_count = 0;
      csr_write_enable = 1'b0;
      csr_index = CsrIndexWindow;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      sample_time = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under reset register values: clear on an empty ring, a lone
      // sample, a second one with a too-short span, a valid third one, level extremes.
      send_item(OpClear, 32'hFFFF_FFFF, 24'hFFFFFF);
      push_sample(32'd0, 24'h7FFFFF);
      push_sample(32'd1000, 24'h800000);
      push_sample(32'd70000, 24'h800000);
      push_sample(32'd200000, 24'h7FFFFF);
      push_sample(32'd2500000, 24'h000001);
      send_item(OpClear, 32'd0, 24'd0);
      // Timestamps that wrap through zero.
      push_sample(32'hFFFF_0000, 24'h123456);
      push_sample(32'h0001_0000, 24'hFEDCBA);
      push_sample(32'h0003_0000, 24'h000000);
      settle();

      // Widest window and no minimum span: equal times give a zero denominator,
      // and large level jumps over one millisecond saturate both ways.
      write_csr(CsrIndexWindow, 32'hFFFF_FFFF);
      write_csr(CsrIndexMinSpan, 32'd0);
      send_item(OpClear, 32'd0, 24'd0);
      push_sample(32'd500, 24'h800000);
      push_sample(32'd500, 24'h7FFFFF);
      push_sample(32'd500, 24'h000000);
      send_item(OpClear, 32'd0, 24'd0);
      push_sample(32'd10, 24'h800000);
      push_sample(32'd11, 24'h7FFFFF);
      send_item(OpClear, 32'd0, 24'd0);
      push_sample(32'd10, 24'h7FFFFF);
      push_sample(32'd11, 24'h800000);
      run_series(100, 3);
      settle();

      // Narrowest window: nearly every push evicts the whole ring.
      write_csr(CsrIndexWindow, 32'd1);
      run_series(50, 2);
      settle();

      // Back to the usual values; long runs fill the ring and drop the oldest.
      write_csr(CsrIndexWindow, WindowResetValue);
      write_csr(CsrIndexMinSpan, MinSpanResetValue);
      run_series(80, 90000);
      // Hold off until every expected result has come back.
      req_if.valid = 1'b0;
      while (slopes_pending != 0) @(negedge clock);
      run_series(80, 90000);
      settle();

      // Largest minimum span: no slope is ever valid.
      write_csr(CsrIndexWindow, $urandom());
      write_csr(CsrIndexMinSpan, 32'hFFFF_FFFF);
      run_series(40, 200000);
      settle();

      // Random settings and, for the closing part, no idling on either side.
      write_csr(CsrIndexWindow, $urandom_range(100000, 3000000));
      write_csr(CsrIndexMinSpan, $urandom_range(0, 50000));
      run_series(60, 40000);
      quiet = 1'b1;
      run_series(80, 40000);
      settle();

      if (mismatch_count == 0 && slopes_pending == 0) begin
         $display("[windowed_slope_estimator] OK");
      end else begin
         $display("[windowed_slope_estimator] ERROR");
      end
      $finish;
   end

endmodule

FILE: windowed_slope_estimator.f
src/wse_pkg.sv
src/wse_stream_if.sv
src/wse_ctrl.sv
src/wse_datapath.sv
src/windowed_slope_estimator.sv
src/wse_checker.sv
tb/sv/wse_slope_checker.sv
tb/sv/tb_windowed_slope_estimator.sv
